### rtl/lome_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_pkg
// shared types and codes of the order matching engine
// ----------------------------------------------------------------------------
package lome_pkg;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam int unsigned ArrW = 40;
  localparam int unsigned CntW = 7;

  typedef struct packed {
    logic        cmd;
    logic        side;
    logic [31:0] order_id;
    logic [31:0] order_price;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     buy_id;
    logic [31:0]     sell_id;
    logic [31:0]     exec_price;
    logic [CntW-1:0] buys_resting;
    logic [CntW-1:0] sells_resting;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/limit_order_match_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_match_engine
// price-time priority matching over a bounded table of resting orders
// ----------------------------------------------------------------------------
// s_axis carries commands (submit or cancel); m_axis returns one status
// transaction per command, with trade ids and price on a match and the
// resting counts after the command.
// a two-entry queue takes commands while the table engine is busy.
// each command scans every slot through one read port of the slot memory,
// and the table engine takes the next command only after the result of
// the last one is taken; a result also waits for the commands queued ahead.
// reset empties the table and clears counts and the arrival counter at once.
// when m_axis stalls the result is held and the next command waits in
// the queue; s_axis_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module limit_order_match_engine
  import lome_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         s_axis_tvalid,
  output logic               s_axis_tready,
  // order_id [31:0], order_price [63:32]
  input  wire  logic [63:0]  s_axis_tdata,
  // cmd [0], side [1]
  input  wire  logic [1:0]   s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire  logic         m_axis_tready,
  // buy_id [31:0], sell_id [63:32], exec_price [95:64],
  // buys_resting [102:96], sells_resting [109:103], zero fill [111:110]
  output logic [111:0]       m_axis_tdata,
  // status [2:0]
  output logic [2:0]         m_axis_tuser
);

  req_t in_req, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign in_req.cmd         = s_axis_tuser[0];
  assign in_req.side        = s_axis_tuser[1];
  assign in_req.order_id    = s_axis_tdata[31:0];
  assign in_req.order_price = s_axis_tdata[63:32];

  lome_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  lome_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_book (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rsp_o   (rsp)
  );

  assign m_axis_tuser = rsp.status;
  assign m_axis_tdata = {2'b00, rsp.sells_resting, rsp.buys_resting,
                         rsp.exec_price, rsp.sell_id, rsp.buy_id};

endmodule
`default_nettype wire

### rtl/lome_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_front
// two-entry request queue feeding the book engine
// ----------------------------------------------------------------------------
module lome_front
  import lome_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  req_t in_req_i,
  output logic       q_valid_o,
  input  wire  logic q_ready_i,
  output req_t       q_req_o
);

  localparam int unsigned QDepth = 2;

  req_t       mem_q [QDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_req_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count overflow");
  a_full_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QDepth)) |-> !in_ready_o) else $error("ready while full");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");

endmodule
`default_nettype wire

### rtl/lome_book.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_book
// order table and sequential scan for match, free slot or cancel target
// ----------------------------------------------------------------------------
module lome_book
  import lome_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic q_valid_i,
  output logic       q_ready_o,
  input  wire  req_t q_req_i,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output rsp_t       out_rsp_o
);

  localparam int unsigned IdxW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // slot memories, read one address per cycle with registered data
  logic            valid_q [BOOK_DEPTH];
  logic            side_m  [BOOK_DEPTH];
  logic [31:0]     id_m    [BOOK_DEPTH];
  logic [31:0]     pr_m    [BOOK_DEPTH];
  logic [ArrW-1:0] arr_m   [BOOK_DEPTH];

  logic [1:0]      st_q;
  req_t            req_q;
  logic [IdxW:0]   ra_q;        // read address, one past the end stops issue
  logic            rv_q;        // read data valid
  logic [IdxW-1:0] rx_q;        // index of read data
  logic            r_vld_q, r_side_q;
  logic [31:0]     r_id_q, r_pr_q;
  logic [ArrW-1:0] r_arr_q;

  logic            bf_q, bb_q;  // best found, best is buy (cancel)
  logic [IdxW-1:0] bi_q;
  logic [31:0]     bid_q, bpr_q;
  logic [ArrW-1:0] barr_q;
  logic            ff_q;
  logic [IdxW-1:0] fi_q;

  logic [ArrW-1:0] arrc_q;
  logic [CntW-1:0] buys_q, sells_q;
  rsp_t            rsp_q;

  logic            take, ok, better, last;

  assign q_ready_o   = (st_q == S_IDLE);
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = (st_q == S_OUT);
  assign out_rsp_o   = rsp_q;
  assign last        = rv_q && (rx_q == IdxW'(BOOK_DEPTH - 1));

  // candidate evaluation for the slot just read
  always_comb begin
    ok     = 1'b0;
    better = 1'b0;
    if (req_q.cmd == CMD_SUBMIT) begin
      ok = r_vld_q && (r_side_q != req_q.side) &&
           ((req_q.side == SIDE_SELL) ? (r_pr_q >= req_q.order_price)
                                      : (r_pr_q <= req_q.order_price));
      if (!bf_q) begin
        better = 1'b1;
      end else if (r_pr_q != bpr_q) begin
        better = (req_q.side == SIDE_SELL) ? (r_pr_q > bpr_q) : (r_pr_q < bpr_q);
      end else begin
        better = r_arr_q < barr_q;
      end
    end else begin
      ok = r_vld_q && (r_id_q == req_q.order_id) &&
           ((r_side_q == SIDE_BUY) || !bb_q);
      if (r_side_q == SIDE_BUY) begin
        better = !bb_q || (r_arr_q < barr_q);
      end else begin
        better = !bf_q || (r_arr_q > barr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      rv_q    <= 1'b0;
      ra_q    <= '0;
      bf_q    <= 1'b0;
      bb_q    <= 1'b0;
      ff_q    <= 1'b0;
      arrc_q  <= '0;
      buys_q  <= '0;
      sells_q <= '0;
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      case (st_q)
        S_IDLE: begin
          if (take) begin
            st_q <= S_SCAN;
            ra_q <= '0;
            rv_q <= 1'b0;
            bf_q <= 1'b0;
            bb_q <= 1'b0;
            ff_q <= 1'b0;
          end
        end
        S_SCAN: begin
          rv_q <= (ra_q < (IdxW+1)'(BOOK_DEPTH));
          if (ra_q < (IdxW+1)'(BOOK_DEPTH)) begin
            ra_q <= ra_q + 1'b1;
          end
          r_vld_q <= valid_q[ra_q[IdxW-1:0]];
          if (rv_q) begin
            if (ok && better) begin
              bf_q <= 1'b1;
              bi_q <= rx_q;
              if (req_q.cmd == CMD_CANCEL) begin
                bb_q <= (r_side_q == SIDE_BUY);
              end
            end
            if (!r_vld_q && !ff_q) begin
              ff_q <= 1'b1;
              fi_q <= rx_q;
            end
          end
          if (last) begin
            st_q <= S_DONE;
          end
        end
        S_DONE: begin
          st_q          <= S_OUT;
          rsp_q.buy_id     <= '0;
          rsp_q.sell_id    <= '0;
          rsp_q.exec_price <= '0;
          rsp_q.buys_resting  <= buys_q;
          rsp_q.sells_resting <= sells_q;
          if (req_q.cmd == CMD_CANCEL) begin
            if (bf_q) begin
              valid_q[bi_q] <= 1'b0;
              rsp_q.status  <= ST_CANCELLED;
              if (bb_q) begin
                buys_q <= buys_q - 1'b1;
                rsp_q.buys_resting <= buys_q - 1'b1;
              end else begin
                sells_q <= sells_q - 1'b1;
                rsp_q.sells_resting <= sells_q - 1'b1;
              end
            end else begin
              rsp_q.status <= ST_NOT_FOUND;
            end
          end else if (bf_q) begin
            valid_q[bi_q]    <= 1'b0;
            rsp_q.status     <= ST_MATCHED;
            rsp_q.exec_price <= bpr_q;
            if (req_q.side == SIDE_SELL) begin
              rsp_q.buy_id  <= bid_q;
              rsp_q.sell_id <= req_q.order_id;
              buys_q <= buys_q - 1'b1;
              rsp_q.buys_resting <= buys_q - 1'b1;
            end else begin
              rsp_q.buy_id  <= req_q.order_id;
              rsp_q.sell_id <= bid_q;
              sells_q <= sells_q - 1'b1;
              rsp_q.sells_resting <= sells_q - 1'b1;
            end
          end else if (ff_q) begin
            valid_q[fi_q] <= 1'b1;
            arrc_q        <= arrc_q + 1'b1;
            rsp_q.status  <= ST_RESTED;
            if (req_q.side == SIDE_SELL) begin
              sells_q <= sells_q + 1'b1;
              rsp_q.sells_resting <= sells_q + 1'b1;
            end else begin
              buys_q <= buys_q + 1'b1;
              rsp_q.buys_resting <= buys_q + 1'b1;
            end
          end else begin
            rsp_q.status <= ST_FULL;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // payload side: memory ports and best-candidate data
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= q_req_i;
    end
    rx_q     <= ra_q[IdxW-1:0];
    r_side_q <= side_m[ra_q[IdxW-1:0]];
    r_id_q   <= id_m[ra_q[IdxW-1:0]];
    r_pr_q   <= pr_m[ra_q[IdxW-1:0]];
    r_arr_q  <= arr_m[ra_q[IdxW-1:0]];
    if (st_q == S_SCAN && rv_q && ok && better) begin
      bid_q  <= r_id_q;
      bpr_q  <= r_pr_q;
      barr_q <= r_arr_q;
    end
    if (st_q == S_DONE && req_q.cmd == CMD_SUBMIT && !bf_q && ff_q) begin
      side_m[fi_q] <= req_q.side;
      id_m[fi_q]   <= req_q.order_id;
      pr_m[fi_q]   <= req_q.order_price;
      arr_m[fi_q]  <= arrc_q;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_match_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != ST_MATCHED) |->
      (out_rsp_o.buy_id == 32'd0 && out_rsp_o.exec_price == 32'd0))
    else $error("trade fields set without match");
  a_noready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SCAN) |-> !q_ready_o) else $error("took item while scanning");

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// price-time matching engine: directed and random order flow, every result
// checked against an in-bench order table model
// ----------------------------------------------------------------------------
module testbench;
  import lome_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  limit_order_match_engine #(.BOOK_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // book model
  logic            bk_valid [DEPTH];
  logic            bk_side  [DEPTH];
  logic [31:0]     bk_id    [DEPTH];
  logic [31:0]     bk_price [DEPTH];
  logic [ArrW-1:0] bk_arr   [DEPTH];
  logic [ArrW-1:0] arr_next;
  logic [CntW-1:0] n_buys, n_sells;

  rsp_t expected_trades [$];
  int   mismatch_count;
  int   idle_cycles;
  bit   hold_off;
  bit   random_ready;

  function automatic rsp_t book_result(logic [2:0] st, logic [31:0] b, logic [31:0] s,
                                       logic [31:0] p);
    rsp_t r;
    r.status = st; r.buy_id = b; r.sell_id = s; r.exec_price = p;
    r.buys_resting = n_buys; r.sells_resting = n_sells;
    return r;
  endfunction

  function automatic rsp_t apply_order(req_t q);
    int best;
    int pick;
    bit pick_buy;
    bit ok;
    logic [31:0] rid;
    best = -1;
    pick = -1;
    pick_buy = 0;
    if (q.cmd == CMD_SUBMIT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_side[i] == q.side) continue;
        ok = (q.side == SIDE_SELL) ? (bk_price[i] >= q.order_price)
                                   : (bk_price[i] <= q.order_price);
        if (!ok) continue;
        if (best < 0) best = i;
        else if (bk_price[i] != bk_price[best]) begin
          if ((q.side == SIDE_SELL) ? (bk_price[i] > bk_price[best])
                                    : (bk_price[i] < bk_price[best])) best = i;
        end else if (bk_arr[i] < bk_arr[best]) best = i;
      end
      if (best >= 0) begin
        bk_valid[best] = 0;
        rid = bk_id[best];
        if (q.side == SIDE_SELL) begin
          n_buys--;
          return book_result(ST_MATCHED, rid, q.order_id, bk_price[best]);
        end
        n_sells--;
        return book_result(ST_MATCHED, q.order_id, rid, bk_price[best]);
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i]) begin
          bk_valid[i] = 1; bk_side[i] = q.side; bk_id[i] = q.order_id;
          bk_price[i] = q.order_price; bk_arr[i] = arr_next;
          arr_next++;
          if (q.side == SIDE_SELL) n_sells++; else n_buys++;
          return book_result(ST_RESTED, 0, 0, 0);
        end
      end
      return book_result(ST_FULL, 0, 0, 0);
    end
    // cancel: oldest buy wins, else newest sell
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_valid[i] || bk_id[i] != q.order_id) continue;
      if (bk_side[i] == SIDE_BUY) begin
        if (!pick_buy || bk_arr[i] < bk_arr[pick]) begin
          pick = i; pick_buy = 1;
        end
      end else if (!pick_buy) begin
        if (pick < 0 || bk_arr[i] > bk_arr[pick]) pick = i;
      end
    end
    if (pick < 0) return book_result(ST_NOT_FOUND, 0, 0, 0);
    bk_valid[pick] = 0;
    if (pick_buy) n_buys--; else n_sells--;
    return book_result(ST_CANCELLED, 0, 0, 0);
  endfunction

  // valid stays high between back-to-back transactions, drops only for a gap
  task automatic send_order(logic cmd, logic side, logic [31:0] id, logic [31:0] price);
    req_t q;
    int gap;
    q.cmd = cmd; q.side = side; q.order_id = id; q.order_price = price;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {price, id};
    s_axis_tuser  <= {side, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_trades.push_back(apply_order(q));
  endtask

  // result checker
  always @(posedge clk_i) begin
    rsp_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.buy_id = m_axis_tdata[31:0];
      got.sell_id = m_axis_tdata[63:32];
      got.exec_price = m_axis_tdata[95:64];
      got.buys_resting = m_axis_tdata[102:96];
      got.sells_resting = m_axis_tdata[109:103];
      if (expected_trades.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_trades.pop_front();
        if (got !== exp_r || m_axis_tdata[111:110] !== 2'b00) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    int wait_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      wait_left = 0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (!random_ready) begin
      m_axis_tready <= 1'b1;
    end else if (m_axis_tready && m_axis_tvalid) begin
      wait_left = $urandom_range(0, 6);
      m_axis_tready <= (wait_left == 0);
    end else if (!m_axis_tready) begin
      if (wait_left > 0) wait_left--;
      m_axis_tready <= (wait_left == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  task automatic test_extremes();
    send_order(CMD_CANCEL, SIDE_BUY, 32'd0, 32'hFFFF_FFFF);        // cancel on empty book
    send_order(CMD_SUBMIT, SIDE_BUY, 32'hFFFF_FFFF, 32'd0);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd0, 32'hFFFF_FFFF);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'h1, 32'd0);               // hits buy at 0
    send_order(CMD_SUBMIT, SIDE_BUY, 32'h2, 32'hFFFF_FFFF);        // hits sell at max
    send_order(CMD_SUBMIT, SIDE_BUY, 32'hAAAA_5555, 32'h5555_AAAA);
    send_order(CMD_SUBMIT, SIDE_BUY, 32'h5555_AAAA, 32'hAAAA_5555);
    send_order(CMD_CANCEL, SIDE_SELL, 32'hAAAA_5555, 32'hFFFF_FFFF);
    send_order(CMD_CANCEL, SIDE_BUY, 32'h5555_AAAA, 32'd0);
  endtask

  task automatic test_priority();
    // equal prices: earliest arrival first; best price beats arrival
    send_order(CMD_SUBMIT, SIDE_BUY, 32'd10, 32'd100);
    send_order(CMD_SUBMIT, SIDE_BUY, 32'd11, 32'd100);
    send_order(CMD_SUBMIT, SIDE_BUY, 32'd12, 32'd101);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd20, 32'd100);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd21, 32'd100);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd22, 32'd100);
    // duplicate ids on cancel
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd7, 32'd500);
    send_order(CMD_SUBMIT, SIDE_SELL, 32'd7, 32'd600);
    send_order(CMD_SUBMIT, SIDE_BUY, 32'd7, 32'd50);
    send_order(CMD_SUBMIT, SIDE_BUY, 32'd7, 32'd40);
    for (int i = 0; i < 5; i++) send_order(CMD_CANCEL, SIDE_BUY, 32'd7, 32'd0);
  endtask

  task automatic test_book_full();
    // fill with non-crossing orders, then overflow
    for (int i = 0; i < DEPTH + 3; i++)
      send_order(CMD_SUBMIT, i[0], 32'h100 + i, i[0] ? 32'h8000_0000 + i : 32'h1000 + i);
    for (int i = 0; i < DEPTH + 1; i++)
      send_order(CMD_CANCEL, SIDE_BUY, 32'h100 + i, 32'd0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 8; i++)
        send_order(CMD_SUBMIT, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
                   $urandom_range(90, 110));
      begin
        int cnt;
        cnt = 0;
        while (cnt < 1500) begin
          @(posedge clk_i);
          cnt++;
        end
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic test_random(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6)
        send_order(CMD_SUBMIT, 1'($urandom_range(0, 1)), $urandom_range(0, 40),
                   $urandom_range(95, 105));
      else if (mode < 8)
        send_order(CMD_CANCEL, 1'($urandom_range(0, 1)), $urandom_range(0, 40),
                   rand_word());
      else
        send_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word(),
                   rand_word());
    end
  endtask

  initial begin
    int tail;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    random_ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) bk_valid[i] = 0;
    arr_next = '0;
    n_buys = '0;
    n_sells = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_priority();
    random_ready = 1'b1;
    test_book_full();
    test_backpressure();
    test_random(640);
    s_axis_tvalid <= 1'b0;
    while (expected_trades.size() != 0) @(posedge clk_i);
    tail = 0;
    while (tail < 200) begin
      @(posedge clk_i);
      tail++;
    end
    if (mismatch_count == 0 && expected_trades.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
